// ===== hw/rtl/sct_pkg.sv =====
// shared types and constants for the taylor series sine/cosine block
package sct_pkg;

	// field widths of the request and response
	localparam int ANGLE_W = 32;
	localparam int VALUE_W = 32;

	// fraction bits of the fixed-point formats
	localparam int ANGLE_FRAC = 29;
	localparam int VALUE_FRAC = 30;
	localparam int TERM_FRAC  = 40;
	localparam int RATIO_FRAC = 58;

	// internal datapath widths, sized from the largest values that occur
	// (|x| <= 4, so every term stays below 11.7 and the sum below 55)
	localparam int MAG_W   = 32;
	localparam int X2_W    = 63;
	localparam int RECIP_W = 64;
	localparam int RATIO_W = 62;
	localparam int TERM_W  = 45;
	localparam int ACC_W   = 48;

	// shift of the final rounding from term format to value format
	localparam int RND_SHIFT = TERM_FRAC - VALUE_FRAC;

	// mode codes
	localparam logic MODE_SIN = 1'b0;
	localparam logic MODE_COS = 1'b1;

	// first cosine term, exactly 1.0
	localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << TERM_FRAC;

	// saturation limits of the response value
	localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// request payload
	typedef struct packed {
		logic                      mode;
		logic signed [ANGLE_W-1:0] angle;
	} req_t;

	// response payload
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      saturated;
	} rsp_t;

	// state handed from cell to cell
	typedef struct packed {
		logic                    mode;
		logic [X2_W-1:0]         x2;
		logic [TERM_W-1:0]       term;
		logic                    tneg;
		logic signed [ACC_W-1:0] acc;
	} lane_t;

endpackage

// ===== hw/rtl/sct_head.sv =====
// front stages: angle magnitude, square and first series term
module sct_head import sct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  req_t  in_req,
	output logic  out_valid,
	output lane_t out_lane
);

	logic             v_s1;
	logic             v_s2;
	logic             mode_s1;
	logic             xneg_s1;
	logic [MAG_W-1:0] mag_s1;
	lane_t            lane_s2;
	logic [MAG_W-1:0] angle_u;
	logic [2*MAG_W-1:0] sq;
	lane_t            lane_d;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign angle_u = MAG_W'($unsigned(in_req.angle));

	// sign and magnitude of the angle
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= in_req.mode;
			xneg_s1 <= in_req.angle[ANGLE_W-1];
			mag_s1  <= in_req.angle[ANGLE_W-1] ? (MAG_W'(0) - angle_u) : angle_u;
		end
	end

	// square of the magnitude and first term
	always_comb begin
		sq = (2*MAG_W)'(mag_s1) * (2*MAG_W)'(mag_s1);
		lane_d.mode = mode_s1;
		lane_d.x2   = sq[X2_W-1:0];
		lane_d.acc  = '0;
		if (mode_s1 == MODE_COS) begin
			lane_d.term = TERM_ONE;
			lane_d.tneg = 1'b0;
		end else begin
			lane_d.term = TERM_W'(mag_s1) << (TERM_FRAC - ANGLE_FRAC);
			lane_d.tneg = xneg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s2 <= lane_d;
		end
	end

	assign out_valid = v_s2;
	assign out_lane  = lane_s2;

endmodule

// ===== hw/rtl/sct_cell.sv =====
// one series cell: adds its term and derives the next one
module sct_cell import sct_pkg::*; #(
	parameter int IDX = 1
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  lane_t in_lane,
	output logic  out_valid,
	output lane_t out_lane
);

	localparam int HALF = 32;

	// reciprocals of the divisor for this step, worked out at elaboration
	localparam logic [RECIP_W-1:0] ONES      = '1;
	localparam logic [RECIP_W-1:0] D_SIN     = RECIP_W'((2*IDX) * (2*IDX + 1));
	localparam logic [RECIP_W-1:0] D_COS     = RECIP_W'((2*IDX - 1) * (2*IDX));
	localparam logic [RECIP_W-1:0] RECIP_SIN = ONES / D_SIN;
	localparam logic [RECIP_W-1:0] RECIP_COS = ONES / D_COS;

	// widths of the split products
	localparam int XH_W   = X2_W - HALF;
	localparam int RH_W   = RATIO_W - HALF;
	localparam int TH_W   = TERM_W - HALF;
	localparam int SUM_W  = TH_W + RH_W + HALF;
	localparam int NXT_LO = RATIO_FRAC - HALF;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [RECIP_W-1:0]   recip;
	logic signed [ACC_W-1:0] acc_add;
	lane_t                lane_a;

	logic [2*HALF-1:0]    pp_ll_s1;
	logic [2*HALF-1:0]    pp_lh_s1;
	logic [XH_W+HALF-1:0] pp_hl_s1;
	logic [XH_W+HALF-1:0] pp_hh_s1;
	lane_t                lane_s1;

	logic [2*HALF+1:0]    mid;
	logic [RECIP_W-1:0]   hi;
	logic [RATIO_W-1:0]   ratio_s2;
	lane_t                lane_s2;

	logic [2*HALF-1:0]    q_ll_s3;
	logic [HALF+RH_W-1:0] q_lh_s3;
	logic [TH_W+HALF-1:0] q_hl_s3;
	logic [TH_W+RH_W-1:0] q_hh_s3;
	lane_t                lane_s3;

	logic [2*HALF+1:0]    mid2;
	logic [SUM_W-1:0]     sum;
	lane_t                lane_b;
	lane_t                lane_s4;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// accumulate this term, pick reciprocal by mode
	always_comb begin
		recip = (in_lane.mode == MODE_COS) ? RECIP_COS : RECIP_SIN;
		if (in_lane.tneg) begin
			acc_add = in_lane.acc - $signed(ACC_W'(in_lane.term));
		end else begin
			acc_add = in_lane.acc + $signed(ACC_W'(in_lane.term));
		end
		lane_a     = in_lane;
		lane_a.acc = acc_add;
	end

	// stage 1: partial products of x2 * reciprocal
	always_ff @(posedge clk) begin
		if (adv) begin
			pp_ll_s1 <= (2*HALF)'(in_lane.x2[HALF-1:0]) * (2*HALF)'(recip[HALF-1:0]);
			pp_lh_s1 <= (2*HALF)'(in_lane.x2[HALF-1:0]) * (2*HALF)'(recip[RECIP_W-1:HALF]);
			pp_hl_s1 <= (XH_W+HALF)'(in_lane.x2[X2_W-1:HALF])
				* (XH_W+HALF)'(recip[HALF-1:0]);
			pp_hh_s1 <= (XH_W+HALF)'(in_lane.x2[X2_W-1:HALF])
				* (XH_W+HALF)'(recip[RECIP_W-1:HALF]);
			lane_s1  <= lane_a;
		end
	end

	// stage 2: upper half of the product is the ratio
	always_comb begin
		mid = (2*HALF+2)'(pp_ll_s1[2*HALF-1:HALF]) + (2*HALF+2)'(pp_lh_s1)
			+ (2*HALF+2)'(pp_hl_s1);
		hi  = RECIP_W'(pp_hh_s1) + RECIP_W'(mid[2*HALF+1:HALF]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ratio_s2 <= hi[RATIO_W-1:0];
			lane_s2  <= lane_s1;
		end
	end

	// stage 3: partial products of term * ratio
	always_ff @(posedge clk) begin
		if (adv) begin
			q_ll_s3 <= (2*HALF)'(lane_s2.term[HALF-1:0]) * (2*HALF)'(ratio_s2[HALF-1:0]);
			q_lh_s3 <= (HALF+RH_W)'(lane_s2.term[HALF-1:0])
				* (HALF+RH_W)'(ratio_s2[RATIO_W-1:HALF]);
			q_hl_s3 <= (TH_W+HALF)'(lane_s2.term[TERM_W-1:HALF])
				* (TH_W+HALF)'(ratio_s2[HALF-1:0]);
			q_hh_s3 <= (TH_W+RH_W)'(lane_s2.term[TERM_W-1:HALF])
				* (TH_W+RH_W)'(ratio_s2[RATIO_W-1:HALF]);
			lane_s3 <= lane_s2;
		end
	end

	// stage 4: next term, sign flips
	always_comb begin
		mid2 = (2*HALF+2)'(q_ll_s3[2*HALF-1:HALF]) + (2*HALF+2)'(q_lh_s3)
			+ (2*HALF+2)'(q_hl_s3);
		sum  = {q_hh_s3, {HALF{1'b0}}} + SUM_W'(mid2);
		lane_b      = lane_s3;
		lane_b.term = sum[NXT_LO+TERM_W-1:NXT_LO];
		lane_b.tneg = !lane_s3.tneg;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s4 <= lane_b;
		end
	end

	assign out_valid = v_s4;
	assign out_lane  = lane_s4;

	// the ratio and the next term never need more bits than kept
	a_ratio_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> hi[RECIP_W-1:RATIO_W] == '0)
		else $error("series ratio exceeds its width");

	a_term_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> sum[SUM_W-1:NXT_LO+TERM_W] == '0)
		else $error("series term exceeds its width");

endmodule

// ===== hw/rtl/sct_tail.sv =====
// last term, rounding to Q2.30 and saturation
module sct_tail import sct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  lane_t in_lane,
	output logic  out_valid,
	output rsp_t  out_rsp
);

	localparam int SH_W = ACC_W - RND_SHIFT;

	logic                    v_s1;
	logic                    v_s2;
	logic signed [ACC_W-1:0] acc_f;
	logic signed [ACC_W-1:0] acc_s1;
	logic [ACC_W-1:0]        rnd;
	logic [SH_W-1:0]         sh;
	logic                    sat;
	rsp_t                    rsp_d;
	rsp_t                    rsp_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// final term into the sum
	always_comb begin
		if (in_lane.tneg) begin
			acc_f = in_lane.acc - $signed(ACC_W'(in_lane.term));
		end else begin
			acc_f = in_lane.acc + $signed(ACC_W'(in_lane.term));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s1 <= acc_f;
		end
	end

	// round half up, shift down, clamp to 32 bits
	always_comb begin
		rnd = $unsigned(acc_s1) + (ACC_W'(1) << (RND_SHIFT - 1));
		sh  = rnd[ACC_W-1:RND_SHIFT];
		sat = !((&sh[SH_W-1:VALUE_W-1]) || (~|sh[SH_W-1:VALUE_W-1]));
		rsp_d.saturated = sat;
		if (!sat) begin
			rsp_d.value = $signed(sh[VALUE_W-1:0]);
		end else if (sh[SH_W-1]) begin
			rsp_d.value = $signed(VALUE_MIN);
		end else begin
			rsp_d.value = $signed(VALUE_MAX);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign out_valid = v_s2;
	assign out_rsp   = rsp_s2;

endmodule

// ===== hw/rtl/sct_skid.sv =====
// output register with one skid entry behind it
module sct_skid import sct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  rsp_t in_rsp,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_rsp
);

	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_rsp_q;
	rsp_t skid_rsp_q;
	logic take;
	logic incoming;

	assign take     = out_valid_q && !out_stall;
	assign incoming = in_valid && !skid_valid_q;

	// occupancy of output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else begin
				out_valid_q <= incoming || (out_valid_q && !take);
				if (incoming && out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_rsp_q <= skid_rsp_q;
			end
		end else if (incoming) begin
			if (!out_valid_q || take) begin
				out_rsp_q <= in_rsp;
			end else begin
				skid_rsp_q <= in_rsp;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// the skid entry is used only behind a waiting response
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds data while output is empty");

endmodule

// ===== hw/rtl/sine_cosine_taylor_series.sv =====
// top level of the taylor series sine/cosine block
//
// Takes one request per cycle on req_valid/req_stall/req_data: a Q3.29 angle
// and a mode (sine or cosine). Returns one response per request, in order, on
// rsp_valid/rsp_stall/rsp_data: the NUM_TERMS-term Maclaurin sum in Q2.30,
// saturated, with a flag when it was clamped. No range reduction is done.
//
// The series runs down a row of NUM_TERMS-1 cells that differ only in IDX; each cell adds
// its term to the running sum and forms the next term in four stages (two
// split 64-bit products, each summed in the following stage).
// A request passes the head stages, the cells, the tail stages and the output
// register. Throughput: one request per cycle while the response side takes.
//
// A stalled response sits in the output register; one more result may land
// in a skid entry behind it, after which req_stall goes high and the whole
// pipeline holds until the response is taken. req_stall is a register.
// Reset clears all valids; the block is ready in the first cycle after it.
module sine_cosine_taylor_series import sct_pkg::*; #(
	parameter int NUM_TERMS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	logic                 adv;
	logic                 full;
	logic [NUM_TERMS-1:0] chain_valid;
	lane_t                chain_lane [NUM_TERMS];
	logic                 tail_valid;
	rsp_t                 tail_rsp;

	// pipeline moves unless the skid entry is occupied
	assign adv       = !full;
	assign req_stall = full;

	sct_head u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (req_valid),
		.in_req    (req_data),
		.out_valid (chain_valid[0]),
		.out_lane  (chain_lane[0])
	);

	// row of series cells
	for (genvar k = 0; k < NUM_TERMS - 1; k++) begin : g_cell
		sct_cell #(
			.IDX (k + 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (chain_valid[k]),
			.in_lane   (chain_lane[k]),
			.out_valid (chain_valid[k+1]),
			.out_lane  (chain_lane[k+1])
		);
	end

	sct_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (chain_valid[NUM_TERMS-1]),
		.in_lane   (chain_lane[NUM_TERMS-1]),
		.out_valid (tail_valid),
		.out_rsp   (tail_rsp)
	);

	sct_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tail_valid),
		.in_rsp    (tail_rsp),
		.full      (full),
		.out_valid (rsp_valid),
		.out_stall (rsp_stall),
		.out_rsp   (rsp_data)
	);

	// request side backs up only after a response was held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_stall) |-> $past(rsp_valid && rsp_stall))
		else $error("request stall raised without a held response");

endmodule

// ===== tb/tb_sine_cosine_taylor_series.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the taylor series sine/cosine block
module tb_sine_cosine_taylor_series import sct_pkg::*;;

	localparam int N_TERMS      = 12;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 4 * N_TERMS + 12;
	localparam int HOLD_FROM    = 100;
	localparam int HOLD_LEN     = 300;

	// q2.30 range of the response value
	localparam longint VAL_HI = 64'sd2147483647;
	localparam longint VAL_LO = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	// request and response bookkeeping
	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int unsigned issued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned hold_cyc = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	logic [31:0] corner_angles [11] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h3243_F6A8, 32'hCDBC_0958, 32'h6487_ED51, 32'h9B78_12AF,
		32'h2000_0000, 32'hE000_0000
	};

	sine_cosine_taylor_series #(
		.NUM_TERMS(N_TERMS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	// series sum of one request, rounded and clamped to q2.30
	function automatic rsp_t series_value(req_t r);
		logic [63:0] mag, x2, term, acc, recip, ratio, d, shifted;
		logic [127:0] prod;
		logic tneg, cosine;
		longint sum;
		rsp_t o;
		cosine = (r.mode == MODE_COS);
		mag = r.angle[31] ? (64'h1_0000_0000 - {32'b0, r.angle}) : {32'b0, r.angle};
		x2 = mag * mag;
		if (cosine) begin
			term = 64'd1 << TERM_FRAC;
			tneg = 1'b0;
		end else begin
			term = mag << (TERM_FRAC - ANGLE_FRAC);
			tneg = r.angle[31];
		end
		acc = '0;
		for (int k = 0; k < N_TERMS; k++) begin
			acc = tneg ? acc - term : acc + term;
			if (k + 1 < N_TERMS) begin
				// next term: term * x^2 / d, with 1/d as a truncated q0.64
				d = cosine ? 64'((2 * k + 1) * (2 * k + 2)) : 64'((2 * k + 2) * (2 * k + 3));
				recip = 64'hFFFF_FFFF_FFFF_FFFF / d;
				prod = {64'b0, x2} * {64'b0, recip};
				ratio = prod[127:64];
				prod = {64'b0, term} * {64'b0, ratio};
				term = prod[121:58];
				tneg = ~tneg;
			end
		end
		// round half up from q.40 to q.30
		acc = acc + (64'd1 << (RND_SHIFT - 1));
		shifted = $unsigned($signed(acc) >>> RND_SHIFT);
		sum = $signed(shifted);
		o.saturated = 1'b0;
		if (sum > VAL_HI) begin
			o.value = VALUE_MAX;
			o.saturated = 1'b1;
		end else if (sum < VAL_LO) begin
			o.value = VALUE_MIN;
			o.saturated = 1'b1;
		end else begin
			o.value = shifted[31:0];
		end
		return o;
	endfunction

	task automatic queue_request(logic m, logic [31:0] a);
		req_t r;
		r.mode = m;
		r.angle = a;
		pending_reqs.push_back(r);
	endtask

	// random requests: full range, small angles near zero, and near the extremes
	task automatic queue_random(int n);
		logic [31:0] a;
		logic m;
		for (int i = 0; i < n; i++) begin
			m = ($urandom_range(1) == 0) ? MODE_SIN : MODE_COS;
			case ($urandom_range(3))
				0, 1: a = $urandom;
				2: a = $urandom_range(32'h4000_0000) - 32'h2000_0000;
				default: begin
					if ($urandom_range(1) == 0) a = 32'h7FFF_FFFF - $urandom_range(4095);
					else a = 32'h8000_0000 + $urandom_range(4095);
				end
			endcase
			queue_request(m, a);
		end
	endtask

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// timeout
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && issued_cnt != accepted_cnt) begin
			// hold the request until it is taken
		end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			req_data <= pending_reqs.pop_front();
			req_valid <= 1'b1;
			issued_cnt <= issued_cnt + 1;
		end else begin
			req_valid <= 1'b0;
		end
	end

	// response side stall, with one long hold-off window
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_cyc <= 0;
		end else begin
			hold_cyc <= hold_cyc + 1;
			if (hold_cyc >= HOLD_FROM && hold_cyc < HOLD_FROM + HOLD_LEN) rsp_stall <= 1'b1;
			else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: predict on each taken request, check each taken response
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response value=%h saturated=%b",
						rsp_data.value, rsp_data.saturated);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_data.value !== want.value) begin
						$error("value: expected %h actual %h", want.value, rsp_data.value);
						mismatches++;
					end
					if (rsp_data.saturated !== want.saturated) begin
						$error("saturated: expected %b actual %b",
							want.saturated, rsp_data.saturated);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(series_value(req_data));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

	// reset, stimulus phases and end of run
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no idling; the long receiver hold-off lands in this phase
		@(posedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (corner_angles[i]) begin
			queue_request(MODE_SIN, corner_angles[i]);
			queue_request(MODE_COS, corner_angles[i]);
		end
		queue_random(280);
		while (pending_reqs.size() != 0) @(posedge clk);

		// sender mostly idle
		send_idle_pct = 88;
		recv_stall_pct = 0;
		queue_random(270);
		while (pending_reqs.size() != 0) @(posedge clk);

		// receiver mostly stalling
		send_idle_pct = 0;
		recv_stall_pct = 88;
		queue_random(270);
		while (pending_reqs.size() != 0) @(posedge clk);

		// both sides idle now and then
		send_idle_pct = 20;
		recv_stall_pct = 20;
		queue_random(270);
		while (pending_reqs.size() != 0) @(posedge clk);

		// drain
		@(negedge clk);
		while (issued_cnt != accepted_cnt || expected_rsps.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
